// ===== hdl/session_table_with_timeout_unit_defines.svh =====
// Assertion macros shared by the session table checker.
// No dependencies; included by files that carry assertions.
`ifndef SESSION_TABLE_WITH_TIMEOUT_UNIT_DEFINES_SVH
`define SESSION_TABLE_WITH_TIMEOUT_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define STWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/stwt_pkg.sv =====
// Session table with idle timeout: shared types and constants.
// No dependencies; used by the top level, stwt_ctrl and the testbench.
package stwt_pkg;

  localparam int unsigned SLOTS = 4;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned OUT_SLOT_W = 2;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1800000;

  localparam logic [1:0] MODE_VALIDATE = 2'd0;
  localparam logic [1:0] MODE_CREATE   = 2'd1;
  localparam logic [1:0] MODE_DESTROY  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [31:0] ts;
    logic [31:0] addr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [OUT_SLOT_W-1:0] slot;
  } res_t;

  typedef struct packed {
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
  } mem_req_t;

endpackage

// ===== hdl/session_table_with_timeout_unit.sv =====
// Session table with idle timeout: top level, stream ports and timeout register.
// Depends on stwt_pkg, stwt_ctrl and stwt_ram.
//
// One request is in work at a time. The sequencer reads one slot per cycle
// through the single read port of the table RAM, then, in its finishing
// state, loads the result into the output register and returns to idle to
// take the next request. A validate hit or a create on a free slot stops the
// scan early. A new request may be taken while the previous result still
// waits on the output register. The finishing state waits until that result
// has gone, so a stalled output holds the sequencer.
// Each slot has a valid bit cleared at reset, so no clearing pass follows it.
module session_table_with_timeout_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // mode[1:0], client_ip[33:2], now_ms[65:34], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // session_ok[0], slot_used[2:1], pad
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data  // idle_timeout_ms
);

  logic [31:0]         timeout_r, timeout_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [7:0]          out_tdata_r, out_tdata_nxt;

  logic                start;
  logic                out_free;
  logic                ctrl_idle;
  logic                res_vld;
  stwt_pkg::res_t      res;
  stwt_pkg::req_t      req;
  stwt_pkg::mem_req_t  mem;
  stwt_pkg::entry_t    rd_data;
  logic [stwt_pkg::ENTRY_W-1:0] rd_raw;

  assign in_tready = ctrl_idle;
  assign start     = in_tvalid & in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign req       = '{mode: in_tdata[1:0], ip: in_tdata[33:2], now: in_tdata[65:34]};
  assign rd_data   = stwt_pkg::entry_t'(rd_raw);

  stwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .timeout  (timeout_r),
    .out_free (out_free),
    .idle     (ctrl_idle),
    .res_vld  (res_vld),
    .res      (res),
    .mem      (mem),
    .rd_data  (rd_data)
  );

  stwt_ram #(
    .WIDTH (stwt_pkg::ENTRY_W),
    .DEPTH (stwt_pkg::SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem.wr_en),
    .wr_addr (mem.wr_addr),
    .wr_data (mem.wr_data),
    .rd_en   (mem.rd_en),
    .rd_addr (mem.rd_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    timeout_nxt    = cfg_wr_en ? cfg_wr_data : timeout_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (res_vld) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {5'd0, res.slot, res.ok};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= stwt_pkg::TIMEOUT_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      timeout_r    <= timeout_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== hdl/stwt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module stwt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/stwt_ctrl.sv =====
// Scan sequencer: walks the slots one per cycle, read-modify-write on the table.
// Depends on stwt_pkg.
module stwt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  stwt_pkg::req_t    req,
  input  logic [31:0]       timeout,
  input  logic              out_free,
  output logic              idle,
  output logic              res_vld,
  output stwt_pkg::res_t    res,
  output stwt_pkg::mem_req_t mem,
  input  stwt_pkg::entry_t  rd_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic [31:0]          ip_r, ip_nxt;
  logic [31:0]          now_r, now_nxt;
  stwt_pkg::idx_t       chk_idx_r, chk_idx_nxt;
  stwt_pkg::idx_t       victim_r, victim_nxt;
  logic [31:0]          victim_ts_r, victim_ts_nxt;
  logic                 ok_r, ok_nxt;
  stwt_pkg::idx_t       slot_r, slot_nxt;
  logic [stwt_pkg::SLOTS-1:0] valid_r, valid_nxt;

  stwt_pkg::entry_t     ent;
  logic [31:0]          idle_ms;
  logic                 last;
  logic                 fin;

  // never-written slots read as free with a zero timestamp
  assign ent     = valid_r[chk_idx_r] ? rd_data : '0;
  assign idle_ms = now_r - ent.ts;
  assign last    = (chk_idx_r == stwt_pkg::idx_t'(stwt_pkg::SLOTS - 1));
  assign idle    = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ip_nxt        = ip_r;
    now_nxt       = now_r;
    chk_idx_nxt   = chk_idx_r;
    victim_nxt    = victim_r;
    victim_ts_nxt = victim_ts_r;
    ok_nxt        = ok_r;
    slot_nxt      = slot_r;
    mem           = '0;
    res_vld       = 1'b0;
    res           = '0;
    fin           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mode_nxt      = req.mode;
          ip_nxt        = req.ip;
          now_nxt       = req.now;
          ok_nxt        = 1'b0;
          slot_nxt      = '0;
          victim_nxt    = '0;
          victim_ts_nxt = '0;
          chk_idx_nxt   = '0;
          mem.rd_en     = 1'b1;
          mem.rd_addr   = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem.rd_en   = !last;
        mem.rd_addr = chk_idx_r + 1'b1;
        chk_idx_nxt = chk_idx_r + 1'b1;
        fin         = last;
        case (mode_r)
          stwt_pkg::MODE_VALIDATE: begin
            if (ent.addr != 32'd0 && ent.addr == ip_r) begin
              mem.wr_en   = 1'b1;
              mem.wr_addr = chk_idx_r;
              if (idle_ms < timeout) begin
                mem.wr_data = '{ts: now_r, addr: ent.addr};
                ok_nxt      = 1'b1;
                slot_nxt    = chk_idx_r;
                fin         = 1'b1;
              end else begin
                // expired: free the slot, keep its timestamp
                mem.wr_data = '{ts: ent.ts, addr: 32'd0};
              end
            end
          end
          stwt_pkg::MODE_CREATE: begin
            if (ent.addr == 32'd0) begin
              victim_nxt = chk_idx_r;
              fin        = 1'b1;
            end else if (chk_idx_r == '0 || ent.ts < victim_ts_r) begin
              victim_nxt    = chk_idx_r;
              victim_ts_nxt = ent.ts;
            end
          end
          stwt_pkg::MODE_DESTROY: begin
            if (ent.addr == ip_r) begin
              mem.wr_en   = 1'b1;
              mem.wr_addr = chk_idx_r;
              mem.wr_data = '{ts: ent.ts, addr: 32'd0};
            end
          end
          default: ;
        endcase
        if (fin) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          res_vld   = 1'b1;
          state_nxt = ST_IDLE;
          if (mode_r == stwt_pkg::MODE_CREATE) begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = victim_r;
            mem.wr_data = '{ts: now_r, addr: ip_r};
            res.ok      = 1'b0;
            res.slot    = stwt_pkg::OUT_SLOT_W'(victim_r);
          end else begin
            res.ok      = ok_r;
            res.slot    = stwt_pkg::OUT_SLOT_W'(slot_r);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (mem.wr_en) begin
      valid_nxt[mem.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    ip_r        <= ip_nxt;
    now_r       <= now_nxt;
    chk_idx_r   <= chk_idx_nxt;
    victim_r    <= victim_nxt;
    victim_ts_r <= victim_ts_nxt;
    ok_r        <= ok_nxt;
    slot_r      <= slot_nxt;
  end

endmodule

// ===== hdl/stwt_checker.sv =====
// Port-level checks for the session table, bound to the top level.
// Depends on session_table_with_timeout_unit_defines.svh.
`include "session_table_with_timeout_unit_defines.svh"

module stwt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_tvalid & out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `STWT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `STWT_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_tready, "request taken while one is in work")
  `STWT_ASSERT_NOW(a_no_spurious, out_tvalid, pend_r != 2'd0, "result without a pending request")
  `STWT_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[7:3] == 5'd0, "padding bits of result set")

endmodule

bind session_table_with_timeout_unit stwt_checker u_stwt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_session_table_with_timeout_unit.sv =====
// Testbench for session_table_with_timeout_unit: directed and random stream requests,
// checked against a cycle-free model of the session table held in a scoreboard class.
// Depends on stwt_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_session_table_with_timeout_unit;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS = 190;

  class session_scoreboard;
    logic [31:0] addr [stwt_pkg::SLOTS];
    logic [31:0] ts [stwt_pkg::SLOTS];
    logic [31:0] timeout;
    stwt_pkg::res_t due [$];
    int unsigned errors, checked, hits, expiries, evictions;

    function new();
      for (int i = 0; i < stwt_pkg::SLOTS; i++) begin
        addr[i] = '0;
        ts[i] = '0;
      end
      timeout = stwt_pkg::TIMEOUT_RESET;
      errors = 0;
      checked = 0;
      hits = 0;
      expiries = 0;
      evictions = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_request(logic [1:0] mode, logic [31:0] ip, logic [31:0] now);
      stwt_pkg::res_t r;
      logic [31:0] idle;
      int victim;
      bit placed;
      r = '0;
      victim = 0;
      placed = 0;
      case (mode)
        stwt_pkg::MODE_VALIDATE: begin
          for (int i = 0; i < stwt_pkg::SLOTS; i++) begin
            if (addr[i] != 0 && addr[i] == ip) begin
              idle = now - ts[i];
              if (idle < timeout) begin
                ts[i] = now;
                r.ok = 1'b1;
                r.slot = stwt_pkg::OUT_SLOT_W'(i);
                hits++;
                break;
              end
              addr[i] = '0;
              expiries++;
            end
          end
        end
        stwt_pkg::MODE_CREATE: begin
          for (int i = 0; i < stwt_pkg::SLOTS; i++) begin
            if (addr[i] == 0) begin
              victim = i;
              placed = 1;
              break;
            end
            if (ts[i] < ts[victim]) victim = i;
          end
          if (!placed) evictions++;
          addr[victim] = ip;
          ts[victim] = now;
          r.slot = stwt_pkg::OUT_SLOT_W'(victim);
        end
        stwt_pkg::MODE_DESTROY: begin
          for (int i = 0; i < stwt_pkg::SLOTS; i++)
            if (addr[i] == ip) addr[i] = '0;
        end
        default: ;
      endcase
      due.push_back(r);
    endfunction

    function void check_result(logic ok, logic [stwt_pkg::OUT_SLOT_W-1:0] slot);
      stwt_pkg::res_t e;
      checked++;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: ok=%0d slot=%0d", $time, ok, slot);
        return;
      end
      e = due.pop_front();
      if (ok !== e.ok) begin
        errors++;
        $display("%0t: session_ok mismatch: expected %0d, got %0d", $time, e.ok, ok);
      end
      if (slot !== e.slot) begin
        errors++;
        $display("%0t: slot_used mismatch: expected %0d, got %0d", $time, e.slot, slot);
      end
    endfunction

    function void check_leftover();
      if (due.size() != 0) begin
        errors++;
        $display("%0t: %0d expected results never arrived", $time, due.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  session_scoreboard sb;
  bit            quiet = 1'b0;
  int unsigned   out_hold = 0;
  int unsigned   cycles = 0;
  int unsigned   cfg_writes = 0;
  logic [31:0]   clock_ms = '0;
  logic [31:0]   ip_pool [5];

  session_table_with_timeout_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_session_table_with_timeout_unit: errors");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[0], out_tdata[2:1]);

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_tready = 1'b0;
      out_hold--;
    end else begin
      out_tready = 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25) out_hold = pick_gap();
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [31:0] ip,
                              input logic [31:0] now);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'b0, now, ip, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, ip, now);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.timeout = value;
    cfg_writes++;
  endtask

  task automatic random_request();
    int unsigned r;
    logic [1:0]  mode;
    logic [31:0] ip;
    r = $urandom_range(0, 99);
    if (r < 50) mode = stwt_pkg::MODE_VALIDATE;
    else if (r < 80) mode = stwt_pkg::MODE_CREATE;
    else if (r < 95) mode = stwt_pkg::MODE_DESTROY;
    else mode = MODE_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 80) ip = ip_pool[$urandom_range(0, 4)];
    else if (r < 88) ip = '0;
    else ip = $urandom;
    // time mostly creeps forward; often lands on an expiry boundary of a slot
    r = $urandom_range(0, 99);
    if (r < 40) clock_ms = clock_ms + $urandom_range(0, sb.timeout >> 2);
    else if (r < 70)
      clock_ms = sb.ts[$urandom_range(0, stwt_pkg::SLOTS-1)] + sb.timeout - 1
                 + $urandom_range(0, 2);
    else if (r < 85) clock_ms = clock_ms + $urandom_range(0, 3);
    else clock_ms = $urandom;
    send_request(mode, ip, clock_ms);
  endtask

  initial begin
    logic [31:0] phase_timeout [7];
    sb = new();
    ip_pool[0] = 32'hC0A8_0001;
    ip_pool[1] = 32'hFFFF_FFFF;
    ip_pool[2] = 32'h0000_0001;
    ip_pool[3] = 32'h8000_0000;
    ip_pool[4] = $urandom | 32'h1;
    phase_timeout[0] = 32'hFFFF_FFFF;
    phase_timeout[1] = 32'd1;
    phase_timeout[2] = stwt_pkg::TIMEOUT_RESET;
    phase_timeout[3] = $urandom_range(16, 4000);
    phase_timeout[4] = $urandom | 32'h1;
    phase_timeout[5] = 32'd1000;
    phase_timeout[6] = 32'd300;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset timeout: refresh just inside, then expire
    send_request(stwt_pkg::MODE_CREATE,   32'h0A00_0001, 32'd0);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0A00_0001, 32'd1799999);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0A00_0001, 32'd3599999);

    write_timeout(32'd100);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0,         32'd10);
    send_request(stwt_pkg::MODE_CREATE,   32'h0A00_0001, 32'd10);
    send_request(stwt_pkg::MODE_CREATE,   32'h0,         32'd20);
    send_request(stwt_pkg::MODE_CREATE,   32'h0A00_0001, 32'd30);
    send_request(stwt_pkg::MODE_CREATE,   32'h0A00_0002, 32'd5);
    send_request(stwt_pkg::MODE_CREATE,   32'h0A00_0003, 32'd5);
    send_request(stwt_pkg::MODE_CREATE,   32'h0A00_0004, 32'd40);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0A00_0001, 32'd109);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0A00_0003, 32'd105);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0A00_0003, 32'd106);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0,         32'd106);
    send_request(stwt_pkg::MODE_DESTROY,  32'h0A00_0001, 32'd0);
    send_request(MODE_UNUSED,             32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(stwt_pkg::MODE_CREATE,   32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_request(stwt_pkg::MODE_VALIDATE, 32'hFFFF_FFFF, 32'h0000_0050);
    send_request(stwt_pkg::MODE_DESTROY,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(stwt_pkg::MODE_VALIDATE, 32'h0A00_0004, 32'd41);
    send_request(stwt_pkg::MODE_CREATE,   32'h8000_0000, 32'hFFFF_FFFF);
    send_request(stwt_pkg::MODE_CREATE,   32'h5555_AAAA, 32'h0);
    send_request(stwt_pkg::MODE_DESTROY,  32'h0,         32'h0);

    for (int p = 0; p < 7; p++) begin
      write_timeout(phase_timeout[p]);
      clock_ms = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        quiet = (n % 64) < 12;
        if (p == 3 && n == PHASE_ITEMS / 2) wait_idle();
        random_request();
      end
    end
    quiet = 1'b0;
    wait_idle();
    sb.check_leftover();

    $display("covered %0d results over %0d timeout settings: %0d hits, %0d expiries, %0d evictions",
             sb.checked, cfg_writes, sb.hits, sb.expiries, sb.evictions);
    if (sb.errors == 0) begin
      $display("tb_session_table_with_timeout_unit: clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_session_table_with_timeout_unit: errors");
    end
    $finish;
  end

endmodule

// ===== session_table_with_timeout_unit.f =====
+incdir+hdl
hdl/stwt_pkg.sv
hdl/stwt_ram.sv
hdl/stwt_ctrl.sv
hdl/session_table_with_timeout_unit.sv
hdl/stwt_checker.sv
sim/tb_session_table_with_timeout_unit.sv
